### rtl/morse_code_keyer_assert.svh
// ----------------------------------------------------------------------------
// Morse code keyer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MCK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCK_ASSERT_IMP(lbl, ante, cons, msg)
`define MCK_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse code keyer package
// Shared types, constants and the character-to-pattern table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    localparam int WPM_W     = 11;
    localparam int DOT_W     = 11;
    localparam int DUR_W     = 13;
    localparam int PAT_W     = 7;
    localparam int LEN_W     = 3;
    localparam int DIV_STEPS = 11;

    localparam logic [DOT_W-1:0] DIT_NUMERATOR = 11'd1200;
    localparam logic [DOT_W-1:0] RESET_DOT_LEN = 11'd60;
    localparam logic             RESET_LEVEL   = 1'b1;

    // configuration register indexes
    localparam logic CFG_WPM   = 1'b0;
    localparam logic CFG_LEVEL = 1'b1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // segment length codes
    localparam logic [1:0] DITS_1 = 2'd0;
    localparam logic [1:0] DITS_3 = 2'd1;
    localparam logic [1:0] DITS_4 = 2'd2;

    // elements left-aligned, first element in the MSB, 1 = dash
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } t_pat;

    typedef struct packed {
        logic       key_down;
        logic [1:0] dits;
        logic       last;
    } t_seg;

    function automatic t_pat pattern_of(input logic [7:0] c_in);
        logic [7:0] c;
        t_pat       p;
        c = c_in;
        if (c >= 8'h61 && c <= 8'h7a) begin
            c = c - 8'd32;
        end
        p = '{len: 3'd0, bits: 7'b0000000};
        unique case (c)
            "A":   p = '{3'd2, 7'b0100000};
            "B":   p = '{3'd4, 7'b1000000};
            "C":   p = '{3'd4, 7'b1010000};
            "D":   p = '{3'd3, 7'b1000000};
            "E":   p = '{3'd1, 7'b0000000};
            "F":   p = '{3'd4, 7'b0010000};
            "G":   p = '{3'd3, 7'b1100000};
            "H":   p = '{3'd4, 7'b0000000};
            "I":   p = '{3'd2, 7'b0000000};
            "J":   p = '{3'd4, 7'b0111000};
            "K":   p = '{3'd3, 7'b1010000};
            "L":   p = '{3'd4, 7'b0100000};
            "M":   p = '{3'd2, 7'b1100000};
            "N":   p = '{3'd2, 7'b1000000};
            "O":   p = '{3'd3, 7'b1110000};
            "P":   p = '{3'd4, 7'b0110000};
            "Q":   p = '{3'd4, 7'b1101000};
            "R":   p = '{3'd3, 7'b0100000};
            "S":   p = '{3'd3, 7'b0000000};
            "T":   p = '{3'd1, 7'b1000000};
            "U":   p = '{3'd3, 7'b0010000};
            "V":   p = '{3'd4, 7'b0001000};
            "W":   p = '{3'd3, 7'b0110000};
            "X":   p = '{3'd4, 7'b1001000};
            "Y":   p = '{3'd4, 7'b1011000};
            "Z":   p = '{3'd4, 7'b1100000};
            "1":   p = '{3'd5, 7'b0111100};
            "2":   p = '{3'd5, 7'b0011100};
            "3":   p = '{3'd5, 7'b0001100};
            "4":   p = '{3'd5, 7'b0000100};
            "5":   p = '{3'd5, 7'b0000000};
            "6":   p = '{3'd5, 7'b1000000};
            "7":   p = '{3'd5, 7'b1100000};
            "8":   p = '{3'd5, 7'b1110000};
            "9":   p = '{3'd5, 7'b1111000};
            "0":   p = '{3'd5, 7'b1111100};
            ".":   p = '{3'd6, 7'b0101010};
            ",":   p = '{3'd6, 7'b1100110};
            "?":   p = '{3'd6, 7'b0011000};
            8'h27: p = '{3'd6, 7'b0111100};
            "!":   p = '{3'd6, 7'b1010110};
            "/":   p = '{3'd5, 7'b1001000};
            "(":   p = '{3'd5, 7'b1011000};
            ")":   p = '{3'd6, 7'b1011010};
            "&":   p = '{3'd5, 7'b0100000};
            ":":   p = '{3'd6, 7'b1110000};
            ";":   p = '{3'd6, 7'b1010100};
            "=":   p = '{3'd5, 7'b1000100};
            "+":   p = '{3'd5, 7'b0101000};
            "-":   p = '{3'd6, 7'b1000010};
            "_":   p = '{3'd6, 7'b0011010};
            8'h22: p = '{3'd6, 7'b0100100};
            "$":   p = '{3'd7, 7'b0001001};
            "@":   p = '{3'd6, 7'b0110100};
            default: p = '{3'd0, 7'b0000000};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/mck_div.sv
// ----------------------------------------------------------------------------
// Dit length divider
// Restoring divider, one quotient bit per cycle: 1200 / speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_div
    import mck_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WPM_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DOT_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DOT_W-1:0] r_rem,  n_rem;
    logic [DOT_W-1:0] r_num,  n_num;
    logic [WPM_W-1:0] r_div,  n_div;
    logic [DOT_W:0]   trial;
    logic             q_bit;

    always_comb begin
        trial  = {r_rem, r_num[DOT_W-1]};
        q_bit  = (trial >= {{(DOT_W+1-WPM_W){1'b0}}, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = DIT_NUMERATOR;
            n_div  = (i_divisor == '0) ? WPM_W'(1) : i_divisor;
        end else if (r_busy) begin
            // speed zero is treated as one
            n_rem = q_bit ? DOT_W'(trial - {{(DOT_W+1-WPM_W){1'b0}}, r_div})
                          : trial[DOT_W-1:0];
            n_num = {r_num[DOT_W-2:0], q_bit};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_div <= n_div;
    end

    assign o_busy     = r_busy | r_done;
    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

`default_nettype wire

### rtl/mck_seq.sv
// ----------------------------------------------------------------------------
// Element sequencer
// Shifts the pattern out as the output advances, inserting gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mck_seq
    import mck_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_character,
    input  wire logic       i_last_char,
    input  wire logic       i_advance,
    output logic            o_idle,
    output logic            o_seg_valid,
    output t_seg            o_seg
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [PAT_W-1:0] r_pat,   n_pat;
    logic [LEN_W-1:0] r_cnt,   n_cnt;
    logic             r_gap,   n_gap;
    logic             r_tail,  n_tail;
    logic             r_space, n_space;
    t_pat             lookup;

    assign lookup = pattern_of(i_character);

    always_comb begin
        n_state     = r_state;
        n_pat       = r_pat;
        n_cnt       = r_cnt;
        n_gap       = r_gap;
        n_tail      = r_tail;
        n_space     = r_space;
        o_seg_valid = 1'b0;
        o_seg       = '{key_down: 1'b0, dits: DITS_1, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_load) begin
                    n_state = S_RUN;
                    n_pat   = lookup.bits;
                    n_cnt   = lookup.len;
                    n_gap   = 1'b0;
                    n_tail  = !i_last_char;
                    n_space = (i_character == CHAR_SPACE);
                end
            end
            S_RUN: begin
                if (i_advance) begin
                    priority if (r_space) begin
                        o_seg_valid = 1'b1;
                        o_seg       = '{1'b0, DITS_4, 1'b1};
                        n_state     = S_IDLE;
                    end else if (r_gap) begin
                        o_seg_valid = 1'b1;
                        o_seg       = '{1'b0, DITS_1, 1'b0};
                        n_gap       = 1'b0;
                    end else if (r_cnt != '0) begin
                        o_seg_valid = 1'b1;
                        o_seg       = '{1'b1, r_pat[PAT_W-1] ? DITS_3 : DITS_1,
                                        (r_cnt == LEN_W'(1)) && !r_tail};
                        n_pat       = {r_pat[PAT_W-2:0], 1'b0};
                        n_cnt       = r_cnt - LEN_W'(1);
                        n_gap       = (r_cnt != LEN_W'(1));
                        if (r_cnt == LEN_W'(1) && !r_tail) begin
                            n_state = S_IDLE;
                        end
                    end else if (r_tail) begin
                        o_seg_valid = 1'b1;
                        o_seg       = '{1'b0, DITS_3, 1'b1};
                        n_state     = S_IDLE;
                    end else begin
                        // unknown last character: nothing to send
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pat   <= n_pat;
        r_cnt   <= n_cnt;
        r_gap   <= n_gap;
        r_tail  <= n_tail;
        r_space <= n_space;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

`default_nettype wire

### rtl/morse_code_keyer.sv
// ----------------------------------------------------------------------------
// Morse code keyer
// Turns one character per request into a run of timed key segments.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid/o_in_ready   i_character, i_last_char
//   out      source     o_out_valid/i_out_ready key_down, pin_level, duration, last
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A character is loaded, then its segments (up to 14) are issued one by one as the output advances.
// A speed write runs the serial divider, blocking requests and settings until it is done.
// Synchronous active-low reset: 20 wpm (dit 60 ms), active level high.
// An output stall holds the sequencer; the output register frees the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_code_keyer
    import mck_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_character,
    input  wire logic             i_last_char,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_key_down,
    output logic                  o_pin_level,
    output logic [DUR_W-1:0]      o_duration_ms,
    output logic                  o_last_of_run,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [WPM_W-1:0] i_cfg_data
);

`include "morse_code_keyer_assert.svh"

    logic             r_dot_len;
    logic [DOT_W-1:0] r_dot;
    logic             r_level;
    logic             r_out_valid;
    logic             r_key_down, r_pin_level, r_last;
    logic [DUR_W-1:0] r_dur, n_dur;

    logic             div_busy, div_done, div_start;
    logic [DOT_W-1:0] div_quot;
    logic             seq_idle, seq_valid, advance, in_acc, cfg_acc;
    t_seg             seg;

    assign cfg_acc   = i_cfg_valid & o_cfg_ready;
    assign div_start = cfg_acc & (i_cfg_index == CFG_WPM);
    assign in_acc    = i_in_valid & o_in_ready;
    assign advance   = !r_out_valid | i_out_ready;

    assign o_cfg_ready = !div_busy;
    assign o_in_ready  = seq_idle & !div_busy;

    mck_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (i_cfg_data),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    mck_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_acc),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .i_advance   (advance),
        .o_idle      (seq_idle),
        .o_seg_valid (seq_valid),
        .o_seg       (seg)
    );

    always_comb begin
        unique case (seg.dits)
            DITS_3:  n_dur = {2'b00, r_dot} + {1'b0, r_dot, 1'b0};
            DITS_4:  n_dur = {r_dot, 2'b00};
            default: n_dur = {2'b00, r_dot};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot       <= RESET_DOT_LEN;
            r_level     <= RESET_LEVEL;
            r_out_valid <= 1'b0;
            r_dot_len   <= 1'b0;
        end else begin
            r_dot_len <= div_done;
            if (div_done) begin
                r_dot <= div_quot;
            end
            if (cfg_acc && i_cfg_index == CFG_LEVEL) begin
                r_level <= i_cfg_data[0];
            end
            if (seq_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (seq_valid) begin
            r_key_down  <= seg.key_down;
            r_pin_level <= seg.key_down ? r_level : !r_level;
            r_dur       <= n_dur;
            r_last      <= seg.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_down    = r_key_down;
    assign o_pin_level   = r_pin_level;
    assign o_duration_ms = r_dur;
    assign o_last_of_run = r_last;

    `MCK_ASSERT_NXT(a_div_blocks_in, div_start, !o_in_ready, "request taken during division")
    `MCK_ASSERT_IMP(a_seg_slot_free, seq_valid, advance, "segment lost in full output stage")
    `MCK_ASSERT_NXT(a_load_busy, in_acc, !o_in_ready, "sequencer reloaded while running")
    `MCK_ASSERT_NXT(a_dot_updated, div_done, r_dot_len && !div_busy, "dit length not settled")

endmodule

`default_nettype wire

### tb/morse_code_keyer_tb.sv
// ----------------------------------------------------------------------------
// Morse code keyer testbench
// Sends characters and speed/polarity settings to the keyer, predicts each
// run of key segments from the timing rules and checks every segment in order,
// with random gaps on the request side and random stalls on the segment side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_code_keyer_tb;
    import mck_pkg::*;

    localparam int DIT_SCALE_MS = 1200;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0]       source_char;
        logic             key_down;
        logic             pin_level;
        logic [DUR_W-1:0] duration_ms;
        logic             last_of_run;
    } t_seg_rec;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_character   = 8'h00;
    logic             i_last_char   = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic             o_key_down;
    logic             o_pin_level;
    logic [DUR_W-1:0] o_duration_ms;
    logic             o_last_of_run;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index   = CFG_WPM;
    logic [WPM_W-1:0] i_cfg_data    = '0;

    // predictor state
    logic [DOT_W-1:0] dit_ms    = 11'd60;
    logic             key_level = 1'b1;
    t_seg_rec         expected_segs[$];
    t_seg_rec         seg_want;

    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          items_sent  = 0;
    logic [8:0]  stall_phase = '0;

    string text_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@";

    morse_code_keyer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_character   (i_character),
        .i_last_char   (i_last_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key_down    (o_key_down),
        .o_pin_level   (o_pin_level),
        .o_duration_ms (o_duration_ms),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic string morse_pattern(input logic [7:0] ch_in);
        logic [7:0] ch;
        ch = ch_in;
        if (ch >= "a" && ch <= "z") begin
            ch = ch - 8'd32;
        end
        case (ch)
            "A": return ".-";      "B": return "-...";
            "C": return "-.-.";    "D": return "-..";
            "E": return ".";       "F": return "..-.";
            "G": return "--.";     "H": return "....";
            "I": return "..";      "J": return ".---";
            "K": return "-.-";     "L": return ".-..";
            "M": return "--";      "N": return "-.";
            "O": return "---";     "P": return ".--.";
            "Q": return "--.-";    "R": return ".-.";
            "S": return "...";     "T": return "-";
            "U": return "..-";     "V": return "...-";
            "W": return ".--";     "X": return "-..-";
            "Y": return "-.--";    "Z": return "--..";
            "1": return ".----";   "2": return "..---";
            "3": return "...--";   "4": return "....-";
            "5": return ".....";   "6": return "-....";
            "7": return "--...";   "8": return "---..";
            "9": return "----.";   "0": return "-----";
            ".": return ".-.-.-";  ",": return "--..--";
            "?": return "..--..";  8'h27: return ".----.";
            "!": return "-.-.--";  "/": return "-..-.";
            "(": return "-.--.";   ")": return "-.--.-";
            "&": return ".-...";   ":": return "---...";
            ";": return "-.-.-.";  "=": return "-...-";
            "+": return ".-.-.";   "-": return "-....-";
            "_": return "..--.-";  8'h22: return ".-..-.";
            "$": return "...-..-"; "@": return ".--.-.";
            default: return "";
        endcase
    endfunction

    function automatic t_seg_rec key_segment(input logic [7:0] ch, input logic down,
                                             input int dits);
        t_seg_rec    s;
        int unsigned span;
        span          = dit_ms * dits;
        s.source_char = ch;
        s.key_down    = down;
        s.pin_level   = down ? key_level : ~key_level;
        s.duration_ms = span[DUR_W-1:0];
        s.last_of_run = 1'b0;
        return s;
    endfunction

    task automatic predict_char_run(input logic [7:0] ch, input logic last);
        t_seg_rec segs[$];
        string    pat;
        int       k;
        if (ch == " ") begin
            segs.push_back(key_segment(ch, 1'b0, 4));
        end else begin
            pat = morse_pattern(ch);
            for (k = 0; k < pat.len(); k++) begin
                segs.push_back(key_segment(ch, 1'b1, (pat[k] == "-") ? 3 : 1));
                if (k + 1 < pat.len()) begin
                    segs.push_back(key_segment(ch, 1'b0, 1));
                end
            end
            if (!last) begin
                segs.push_back(key_segment(ch, 1'b0, 3));
            end
        end
        if (segs.size() > 0) begin
            segs[segs.size()-1].last_of_run = 1'b1;
        end
        foreach (segs[i]) begin
            expected_segs.push_back(segs[i]);
        end
    endtask

    task automatic apply_setting(input logic index, input logic [WPM_W-1:0] data);
        int unsigned wpm;
        if (index == CFG_WPM) begin
            wpm = (data == 0) ? 1 : data;
            dit_ms = DOT_W'(DIT_SCALE_MS / wpm);
        end else begin
            key_level = data[0];
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_segs.size() == 0) begin
                    report_mismatch($sformatf("segment with nothing pending (dur %0d)",
                                              o_duration_ms));
                end else begin
                    seg_want = expected_segs.pop_front();
                    if (o_key_down !== seg_want.key_down ||
                        o_pin_level !== seg_want.pin_level ||
                        o_duration_ms !== seg_want.duration_ms ||
                        o_last_of_run !== seg_want.last_of_run) begin
                        report_mismatch($sformatf(
                            "char %02h: key %b/%b pin %b/%b dur %0d/%0d last %b/%b",
                            seg_want.source_char, o_key_down, seg_want.key_down,
                            o_pin_level, seg_want.pin_level, o_duration_ms,
                            seg_want.duration_ms, o_last_of_run, seg_want.last_of_run));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_char_run(i_character, i_last_char);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_setting(i_cfg_index, i_cfg_data);
            end
        end
    end

    // segment side stalls: always ready, coin toss, mostly stalled, every third
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= 1'($urandom_range(0, 1));
            2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_phase % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("morse_code_keyer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] ch, input logic last);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
        end
        i_in_valid  <= 1'b1;
        i_character <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_segs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic index, input logic [WPM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        int         r;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            ch = text_chars[$urandom_range(0, text_chars.len() - 1)];
            if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) begin
                ch = ch + 8'd32;
            end
        end else if (r < 85) begin
            ch = " ";
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
        return ch;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_chars();
        send_char("E", 1'b0);
        send_char("T", 1'b0);
        send_char("a", 1'b0);
        send_char("z", 1'b0);
        send_char("Z", 1'b0);
        send_char("@", 1'b0);
        send_char(8'h60, 1'b0);
        send_char("{", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        send_char(8'h0A, 1'b0);
        send_char(" ", 1'b0);
        send_char(" ", 1'b1);
        send_char("$", 1'b0);
        send_char("$", 1'b1);
        send_char("?", 1'b0);
        send_char(8'h27, 1'b0);
        send_char(8'h22, 1'b0);
        send_char("0", 1'b0);
        send_char("9", 1'b1);
        send_char("_", 1'b1);
        settle();
    endtask

    task automatic test_speed_extremes();
        logic [WPM_W-1:0] speeds[7];
        speeds = '{11'd0, 11'd1, 11'd1200, 11'd1201, 11'd2047, 11'd7, 11'd20};
        foreach (speeds[i]) begin
            write_setting(CFG_WPM, speeds[i]);
            send_char("$", 1'b0);
            send_char(" ", 1'b1);
            send_char("0", 1'b1);
            settle();
        end
    endtask

    task automatic test_active_level();
        write_setting(CFG_LEVEL, 11'd0);
        send_char("R", 1'b0);
        send_char(" ", 1'b0);
        send_char("k", 1'b1);
        settle();
        write_setting(CFG_LEVEL, 11'h7FE);
        send_char("Q", 1'b1);
        settle();
        write_setting(CFG_LEVEL, 11'h7FF);
        send_char("S", 1'b0);
        send_char("O", 1'b1);
        settle();
    endtask

    task automatic test_random_text();
        int               r;
        int               texts;
        int               len;
        logic             noisy;
        logic [WPM_W-1:0] wpm;
        int               start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                wpm = '0;
            end else if (r < 16) begin
                wpm = WPM_W'($urandom_range(1201, 2047));
            end else if (r < 24) begin
                wpm = $urandom_range(0, 1) ? 11'd1 : 11'd1200;
            end else if (r < 60) begin
                wpm = WPM_W'($urandom_range(5, 60));
            end else begin
                wpm = WPM_W'($urandom_range(1, 1200));
            end
            write_setting(CFG_WPM, wpm);
            write_setting(CFG_LEVEL, WPM_W'($urandom_range(0, 2047)));
            texts = $urandom_range(2, 5);
            repeat (texts) begin
                len   = $urandom_range(1, 8);
                noisy = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    send_char(random_char(),
                              noisy ? 1'($urandom_range(0, 1)) : (k == len - 1));
                end
            end
            settle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_chars();
        test_speed_extremes();
        test_active_level();
        test_random_text();
        settle();
        if (error_count == 0) begin
            $display("morse_code_keyer verification clean");
        end else begin
            $display("morse_code_keyer verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/mck_pkg.sv
rtl/mck_div.sv
rtl/mck_seq.sv
rtl/morse_code_keyer.sv
tb/morse_code_keyer_tb.sv
